>>> rtl/t3n_pkg.sv
`default_nettype none
package t3n_pkg;

  // Internal node index width, also the width of the node count register.
  localparam int CNT_W = 17;
  localparam int SIDE_W = 7;

  // Splitter divides two quotient bits per cycle.
  localparam int DIV_W = 18;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Six neighbor steps: minus x, y, z, then plus x, y, z.
  localparam int AXES = 3;
  localparam int NUM_STEPS = 2 * AXES;
  localparam int STEP_W = 3;
  localparam int NF_W = 3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Index arithmetic widths: (px*s + py) and ((px*s + py)*s + pz).
  localparam int ACC_W = 2 * SIDE_W;
  localparam int VAL_W = 3 * SIDE_W;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUBE_SIDE = 1'd1;

  typedef logic [CNT_W-1:0] idx_t;
  typedef logic [SIDE_W-1:0] side_t;

  // One request after coordinate split, with the coordinates of the last node.
  typedef struct packed {
    idx_t  self_idx;
    idx_t  cx;
    side_t cy;
    side_t cz;
    idx_t  lx;
    side_t ly;
    side_t lz;
    side_t side;
  } job_t;

  typedef enum logic [1:0] {
    SP_IDLE,
    SP_DIV1,
    SP_DIV2,
    SP_DONE
  } split_state_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_RUN,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_POS,
    B_MUL1,
    B_MUL2,
    B_CHK,
    B_END
  } back_state_t;

endpackage
`default_nettype wire

>>> rtl/torus3d_neighbor_list.sv
`default_nettype none
// Neighbor list of a node on a 3D torus over a partly filled cube.
//
// s_tvalid/s_tready/s_tdata carry one request item: a node index. Each request
// gives zero to six result items on m_tvalid/m_tready/m_tdata, neighbor index
// in tdata and tlast on the final neighbor. A request at or above the node
// count gives nothing; it is dropped at the edge that takes it, and the front
// can take another item at the next edge.
// The front splits the index by the cube side in two divisions and queues the
// request; it takes no new item until that request is queued. For each step
// the back runs a position state and, if the position holds a node, two
// multiply-add states and a check; each request also passes an idle and an end
// state. A two-entry queue between front and back lets the front take new
// requests while the back is still emitting. When the receiver stalls, the
// output register holds its item and the back waits; once the queue fills, the
// front holds its request and s_tready stays low. Reset (synchronous) sets
// node_count and cube_side to one and empties the queue and all state machines.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only with no request in flight, and the block does not enforce it.
module torus3d_neighbor_list #(
  parameter int INDEX_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [INDEX_BITS-1:0] node_index, rest zero
  input  wire logic [((INDEX_BITS+7)/8)*8-1:0]   s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [INDEX_BITS-1:0] neighbor_index, rest zero
  output logic [((INDEX_BITS+7)/8)*8-1:0]        m_tdata,
  output logic                                   m_tlast,
  input  wire logic                              cfg_we,
  input  wire logic [t3n_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [t3n_pkg::CNT_W-1:0]         cfg_data
);

  localparam int TDATA_W = ((INDEX_BITS + 7) / 8) * 8;

  t3n_pkg::idx_t           node_count;
  t3n_pkg::side_t          cube_side;
  logic                    push, full, pop, empty;
  t3n_pkg::job_t           push_data, pop_data;
  logic [INDEX_BITS-1:0]   out_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= t3n_pkg::idx_t'(1);
      cube_side  <= t3n_pkg::side_t'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        t3n_pkg::CFG_NODE_COUNT: node_count <= cfg_data;
        t3n_pkg::CFG_CUBE_SIDE:  cube_side <= cfg_data[t3n_pkg::SIDE_W-1:0];
        default:                 node_count <= node_count;
      endcase
    end
  end

  t3n_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .node_index (s_tdata[INDEX_BITS-1:0]),
    .node_count (node_count),
    .cube_side  (cube_side),
    .push       (push),
    .push_data  (push_data),
    .full       (full)
  );

  t3n_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  t3n_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (pop_data),
    .empty     (empty),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .out_index (out_index),
    .out_last  (m_tlast)
  );

  assign m_tdata = TDATA_W'(out_index);

endmodule
`default_nettype wire

>>> rtl/t3n_split.sv
`default_nettype none
// Splits an index into (x, y, z): index / side gives z as remainder, the
// quotient divided by side again gives y as remainder and x as quotient.
module t3n_split (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire t3n_pkg::idx_t  idx,
  input  wire t3n_pkg::side_t side,
  output logic                done,
  output t3n_pkg::idx_t       x,
  output t3n_pkg::side_t      y,
  output t3n_pkg::side_t      z
);

  t3n_pkg::split_state_t state, state_next;

  logic [t3n_pkg::DIV_W-1:0]     dq;
  logic [t3n_pkg::DIV_W-1:0]     dq_new;
  t3n_pkg::side_t                rem;
  t3n_pkg::side_t                rem_new;
  t3n_pkg::side_t                sd;
  t3n_pkg::side_t                zr;
  logic [t3n_pkg::DIV_CNT_W-1:0] cnt;
  logic                          cnt_end;
  logic                          step_en;
  logic [t3n_pkg::SIDE_W:0]      r1, r1s, r2, r2s;
  logic                          ge1, ge2;

  // Two restoring division steps per cycle.
  always_comb begin
    r1  = {rem, dq[t3n_pkg::DIV_W-1]};
    ge1 = r1 >= {1'b0, sd};
    r1s = ge1 ? r1 - {1'b0, sd} : r1;
    r2  = {r1s[t3n_pkg::SIDE_W-1:0], dq[t3n_pkg::DIV_W-2]};
    ge2 = r2 >= {1'b0, sd};
    r2s = ge2 ? r2 - {1'b0, sd} : r2;
    dq_new  = {dq[t3n_pkg::DIV_W-3:0], ge1, ge2};
    rem_new = r2s[t3n_pkg::SIDE_W-1:0];
  end

  assign cnt_end = cnt == t3n_pkg::DIV_CNT_W'(t3n_pkg::DIV_STEPS - 1);

  always_comb begin
    state_next = state;
    case (state)
      t3n_pkg::SP_IDLE: if (start) state_next = t3n_pkg::SP_DIV1;
      t3n_pkg::SP_DIV1: if (cnt_end) state_next = t3n_pkg::SP_DIV2;
      t3n_pkg::SP_DIV2: if (cnt_end) state_next = t3n_pkg::SP_DONE;
      t3n_pkg::SP_DONE: state_next = t3n_pkg::SP_IDLE;
      default:          state_next = t3n_pkg::SP_IDLE;
    endcase
  end

  always_comb begin
    done    = 1'b0;
    step_en = 1'b0;
    case (state)
      t3n_pkg::SP_DIV1: step_en = 1'b1;
      t3n_pkg::SP_DIV2: step_en = 1'b1;
      t3n_pkg::SP_DONE: done = 1'b1;
      default: begin
        done    = 1'b0;
        step_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= t3n_pkg::SP_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (start && state == t3n_pkg::SP_IDLE) begin
        cnt <= '0;
      end else if (step_en) begin
        cnt <= cnt_end ? '0 : cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && state == t3n_pkg::SP_IDLE) begin
      dq  <= t3n_pkg::DIV_W'(idx);
      rem <= '0;
      sd  <= side;
    end else if (step_en) begin
      dq <= dq_new;
      if (cnt_end && state == t3n_pkg::SP_DIV1) begin
        zr  <= rem_new;
        rem <= '0;
      end else begin
        rem <= rem_new;
      end
    end
  end

  assign x = dq[t3n_pkg::CNT_W-1:0];
  assign y = rem;
  assign z = zr;

endmodule
`default_nettype wire

>>> rtl/t3n_front.sv
`default_nettype none
// Takes requests, drops those at or above the node count, and splits the
// index and the last node's index into coordinates.
module t3n_front #(
  parameter int INDEX_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [INDEX_BITS-1:0] node_index,
  input  wire t3n_pkg::idx_t         node_count,
  input  wire t3n_pkg::side_t        cube_side,
  output logic                       push,
  output t3n_pkg::job_t              push_data,
  input  wire logic                  full
);

  localparam int CMP_W = ((INDEX_BITS > t3n_pkg::CNT_W) ? INDEX_BITS : t3n_pkg::CNT_W) + 1;

  t3n_pkg::front_state_t state, state_next;

  logic [CMP_W-1:0] cap;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] eff_cnt;
  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] last_ext;
  logic             in_range;
  logic             start;
  t3n_pkg::side_t   side_c;
  t3n_pkg::idx_t    self_r;
  t3n_pkg::side_t   side_r;
  logic             done_s, done_l;
  t3n_pkg::idx_t    xs, xl;
  t3n_pkg::side_t   ys, zs, yl, zl;

  always_comb begin
    cap      = CMP_W'(1) << INDEX_BITS;
    cnt_ext  = CMP_W'(node_count);
    eff_cnt  = (cnt_ext > cap) ? cap : cnt_ext;
    idx_ext  = CMP_W'(node_index);
    in_range = idx_ext < eff_cnt;
    last_ext = eff_cnt - 1'b1;
    side_c   = (cube_side == '0) ? t3n_pkg::side_t'(1) : cube_side;
  end

  assign start = s_tvalid && s_tready && in_range;

  t3n_split u_split_self (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .idx   (idx_ext[t3n_pkg::CNT_W-1:0]),
    .side  (side_c),
    .done  (done_s),
    .x     (xs),
    .y     (ys),
    .z     (zs)
  );

  t3n_split u_split_last (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .idx   (last_ext[t3n_pkg::CNT_W-1:0]),
    .side  (side_c),
    .done  (done_l),
    .x     (xl),
    .y     (yl),
    .z     (zl)
  );

  always_comb begin
    state_next = state;
    case (state)
      t3n_pkg::F_IDLE: if (start) state_next = t3n_pkg::F_RUN;
      t3n_pkg::F_RUN:  if (done_s && done_l) state_next = t3n_pkg::F_PUSH;
      t3n_pkg::F_PUSH: if (!full) state_next = t3n_pkg::F_IDLE;
      default:         state_next = t3n_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    push     = 1'b0;
    case (state)
      t3n_pkg::F_IDLE: s_tready = 1'b1;
      t3n_pkg::F_PUSH: push = !full;
      default: begin
        s_tready = 1'b0;
        push     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= t3n_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      self_r <= idx_ext[t3n_pkg::CNT_W-1:0];
      side_r <= side_c;
    end
  end

  always_comb begin
    push_data.self_idx = self_r;
    push_data.cx       = xs;
    push_data.cy       = ys;
    push_data.cz       = zs;
    push_data.lx       = xl;
    push_data.ly       = yl;
    push_data.lz       = zl;
    push_data.side     = side_r;
  end

endmodule
`default_nettype wire

>>> rtl/t3n_fifo.sv
`default_nettype none
module t3n_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire t3n_pkg::job_t push_data,
  output logic               full,
  input  wire logic          pop,
  output t3n_pkg::job_t      pop_data,
  output logic               empty
);

  t3n_pkg::job_t                  mem [t3n_pkg::FIFO_DEPTH];
  logic [t3n_pkg::FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [t3n_pkg::FIFO_CNT_W-1:0] count;

  assign full     = count == t3n_pkg::FIFO_CNT_W'(t3n_pkg::FIFO_DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

>>> rtl/t3n_back.sv
`default_nettype none
// Walks the six neighbor steps of one request, turns each chosen position into
// an index, drops the node itself and repeats, and streams the survivors.
// One found neighbor is held back so that the final one can carry the last mark.
module t3n_back #(
  parameter int INDEX_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire t3n_pkg::job_t job,
  input  wire logic          empty,
  output logic               pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [INDEX_BITS-1:0] out_index,
  output logic               out_last
);

  t3n_pkg::back_state_t state, state_next;

  t3n_pkg::job_t                ent;
  logic [t3n_pkg::STEP_W-1:0]   step;
  logic [1:0]                   axis;
  logic                         minus;
  logic                         last_step;
  t3n_pkg::idx_t [2:0]          cc, ll;
  t3n_pkg::idx_t [2:0]          p_step, p_zero, p_wrap, pos_c;
  t3n_pkg::idx_t                s_ext, s_max, ca, la, bound, t_wrap;
  logic                         pre_lt, pre_eq, suf_le, wrap_none, ok_c;
  t3n_pkg::side_t [2:0]         pos;
  logic [t3n_pkg::ACC_W-1:0]    acc;
  logic [t3n_pkg::VAL_W-1:0]    val;
  t3n_pkg::idx_t                found [t3n_pkg::NUM_STEPS];
  logic [t3n_pkg::NF_W-1:0]     nf;
  t3n_pkg::idx_t                pend;
  logic                         pend_valid;
  logic                         dup, keep, out_free, hold_chk;
  logic                         step_adv, found_add, out_load, out_last_val;

  function automatic logic holds_node(t3n_pkg::idx_t [2:0] p, t3n_pkg::idx_t [2:0] l,
                                      t3n_pkg::idx_t s);
    logic in_cube;
    logic le;
    in_cube = (p[0] < s) && (p[1] < s) && (p[2] < s);
    le = (p[0] < l[0]) || ((p[0] == l[0]) &&
         ((p[1] < l[1]) || ((p[1] == l[1]) && (p[2] <= l[2]))));
    return in_cube && le;
  endfunction

  // Candidate position for the current step. A position holds a node when it is
  // inside the cube and not past the last node's coordinates.
  always_comb begin
    minus     = step < t3n_pkg::STEP_W'(t3n_pkg::AXES);
    axis      = minus ? step[1:0] : 2'(step - t3n_pkg::STEP_W'(t3n_pkg::AXES));
    last_step = step == t3n_pkg::STEP_W'(t3n_pkg::NUM_STEPS - 1);
    cc[0] = ent.cx;
    cc[1] = t3n_pkg::idx_t'(ent.cy);
    cc[2] = t3n_pkg::idx_t'(ent.cz);
    ll[0] = ent.lx;
    ll[1] = t3n_pkg::idx_t'(ent.ly);
    ll[2] = t3n_pkg::idx_t'(ent.lz);
    s_ext = t3n_pkg::idx_t'(ent.side);
    s_max = s_ext - 1'b1;
    ca    = cc[axis];
    la    = ll[axis];

    p_step       = cc;
    p_step[axis] = minus ? ca - 1'b1 : ca + 1'b1;
    p_zero       = cc;
    p_zero[axis] = '0;

    // The wrap from coordinate zero lands on the highest coordinate that still
    // keeps the position at or before the last node.
    case (axis)
      t3n_pkg::AXIS_X: begin
        pre_lt = 1'b0;
        pre_eq = 1'b1;
        suf_le = (cc[1] < ll[1]) || ((cc[1] == ll[1]) && (cc[2] <= ll[2]));
      end
      t3n_pkg::AXIS_Y: begin
        pre_lt = cc[0] < ll[0];
        pre_eq = cc[0] == ll[0];
        suf_le = cc[2] <= ll[2];
      end
      default: begin
        pre_lt = (cc[0] < ll[0]) || ((cc[0] == ll[0]) && (cc[1] < ll[1]));
        pre_eq = (cc[0] == ll[0]) && (cc[1] == ll[1]);
        suf_le = 1'b1;
      end
    endcase
    wrap_none = 1'b0;
    if (pre_lt) begin
      bound = s_max;
    end else if (pre_eq && suf_le) begin
      bound = la;
    end else if (pre_eq && la != '0) begin
      bound = la - 1'b1;
    end else begin
      bound     = '0;
      wrap_none = 1'b1;
    end
    t_wrap       = (bound > s_max) ? s_max : bound;
    p_wrap       = cc;
    p_wrap[axis] = t_wrap;

    if (minus && ca == '0) begin
      pos_c = p_wrap;
      ok_c  = !wrap_none && holds_node(p_wrap, ll, s_ext);
    end else if (holds_node(p_step, ll, s_ext)) begin
      pos_c = p_step;
      ok_c  = 1'b1;
    end else begin
      pos_c = p_zero;
      ok_c  = holds_node(p_zero, ll, s_ext);
    end
  end

  always_comb begin
    dup = 1'b0;
    for (int k = 0; k < t3n_pkg::NUM_STEPS; k++) begin
      if (t3n_pkg::NF_W'(k) < nf && found[k] == val[t3n_pkg::CNT_W-1:0]) dup = 1'b1;
    end
    keep     = (val != t3n_pkg::VAL_W'(ent.self_idx)) && !dup;
    out_free = !m_tvalid || m_tready;
    hold_chk = keep && pend_valid && !out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      t3n_pkg::B_IDLE: if (!empty) state_next = t3n_pkg::B_POS;
      t3n_pkg::B_POS: begin
        if (ok_c) state_next = t3n_pkg::B_MUL1;
        else state_next = last_step ? t3n_pkg::B_END : t3n_pkg::B_POS;
      end
      t3n_pkg::B_MUL1: state_next = t3n_pkg::B_MUL2;
      t3n_pkg::B_MUL2: state_next = t3n_pkg::B_CHK;
      t3n_pkg::B_CHK: begin
        if (!hold_chk) state_next = last_step ? t3n_pkg::B_END : t3n_pkg::B_POS;
      end
      t3n_pkg::B_END: if (!pend_valid || out_free) state_next = t3n_pkg::B_IDLE;
      default: state_next = t3n_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop          = 1'b0;
    step_adv     = 1'b0;
    found_add    = 1'b0;
    out_load     = 1'b0;
    out_last_val = 1'b0;
    case (state)
      t3n_pkg::B_IDLE: pop = !empty;
      t3n_pkg::B_POS:  step_adv = !ok_c;
      t3n_pkg::B_CHK: begin
        step_adv  = !hold_chk;
        found_add = keep && (!pend_valid || out_free);
        out_load  = keep && pend_valid && out_free;
      end
      t3n_pkg::B_END: begin
        out_load     = pend_valid && out_free;
        out_last_val = 1'b1;
      end
      default: begin
        pop      = 1'b0;
        step_adv = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= t3n_pkg::B_IDLE;
      step       <= '0;
      nf         <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        step       <= '0;
        nf         <= '0;
        pend_valid <= 1'b0;
      end else begin
        if (step_adv) step <= step + 1'b1;
        if (found_add) begin
          nf         <= nf + 1'b1;
          pend_valid <= 1'b1;
        end else if (out_load && state == t3n_pkg::B_END) begin
          pend_valid <= 1'b0;
        end
      end
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) ent <= job;
    if (state == t3n_pkg::B_POS) begin
      for (int i = 0; i < t3n_pkg::AXES; i++) pos[i] <= pos_c[i][t3n_pkg::SIDE_W-1:0];
    end
    if (state == t3n_pkg::B_MUL1) begin
      acc <= t3n_pkg::ACC_W'(pos[0]) * t3n_pkg::ACC_W'(ent.side) + t3n_pkg::ACC_W'(pos[1]);
    end
    if (state == t3n_pkg::B_MUL2) begin
      val <= t3n_pkg::VAL_W'(acc) * t3n_pkg::VAL_W'(ent.side) + t3n_pkg::VAL_W'(pos[2]);
    end
    if (found_add) begin
      found[nf] <= val[t3n_pkg::CNT_W-1:0];
      pend      <= val[t3n_pkg::CNT_W-1:0];
    end
    if (out_load) begin
      out_index <= INDEX_BITS'(pend);
      out_last  <= out_last_val;
    end
  end

endmodule
`default_nettype wire
